### hdl/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg
// shared types, constants and position helpers for the hamming secded codec
// ----------------------------------------------------------------------------
package hsc_pkg;

    // field widths
    localparam int CODE_W   = 64;
    localparam int DATA_W   = 57;
    localparam int POS_W    = 6;
    localparam int BASE_W   = 63;
    localparam int DATA_MAX = 57;
    localparam int MAX_CODE_BITS_DEF = 64;

    // operation codes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_CHECK  = 1'b1;

    // register indexes
    localparam logic CFG_DATA_LENGTH   = 1'b0;
    localparam logic CFG_EXTENDED_MODE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAN  = 2'd0,
        ST_SINGLE = 2'd1,
        ST_PARITY = 2'd2,
        ST_DOUBLE = 2'd3
    } t_status;

    // code geometry derived from the registers
    typedef struct packed {
        logic [POS_W-1:0] m;
        logic [POS_W-1:0] nb;
        logic             ext;
    } t_geom;

    typedef struct packed {
        logic [CODE_W-1:0] code_word;
        logic [DATA_W-1:0] data_out;
        logic [POS_W-1:0]  syndrome;
        logic              overall_parity;
        t_status           status;
        logic [POS_W-1:0]  error_index;
    } t_result;

    // least p with 2^p >= m + p + 1
    function automatic int parity_count(input int m);
        int r;
        r = 7;
        for (int p = 7; p >= 0; p--) begin
            if ((1 << p) >= m + p + 1) r = p;
        end
        return r;
    endfunction

    // largest data length whose code fits max_bits, never below one
    function automatic int max_data(input int max_bits, input int ext);
        int r;
        r = 1;
        for (int m = 1; m <= DATA_MAX; m++) begin
            if (m + parity_count(m) + ext <= max_bits) r = m;
        end
        return r;
    endfunction

    // 1-based position of data bit k (k-th position that is not a power of two)
    function automatic int data_pos(input int k);
        int pos;
        pos = k + 1;
        for (int j = 0; j < 7; j++) begin
            if ((1 << j) <= pos) pos++;
        end
        return pos;
    endfunction

endpackage

### hdl/hsc_cfg.sv
// ----------------------------------------------------------------------------
// hsc_cfg
// configuration registers and code geometry
// ----------------------------------------------------------------------------
module hsc_cfg #(
    parameter int MAX_CODE_BITS = hsc_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic                     i_cfg_index,
    input  logic [hsc_pkg::POS_W-1:0] i_cfg_data,
    output hsc_pkg::t_geom           o_geom
);

    localparam logic [hsc_pkg::POS_W-1:0] LIM0 =
        hsc_pkg::POS_W'(hsc_pkg::max_data(MAX_CODE_BITS, 0));
    localparam logic [hsc_pkg::POS_W-1:0] LIM1 =
        hsc_pkg::POS_W'(hsc_pkg::max_data(MAX_CODE_BITS, 1));
    localparam logic [hsc_pkg::POS_W-1:0] M_MAX = hsc_pkg::POS_W'(hsc_pkg::DATA_MAX);

    logic [hsc_pkg::POS_W-1:0] r_data_length;
    logic                      r_ext_mode;
    logic [hsc_pkg::POS_W-1:0] m_clamp;
    logic [hsc_pkg::POS_W-1:0] m_lim;
    logic [hsc_pkg::POS_W-1:0] m_eff;

    assign o_cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_length <= M_MAX;
            r_ext_mode    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hsc_pkg::CFG_DATA_LENGTH:   r_data_length <= i_cfg_data;
                hsc_pkg::CFG_EXTENDED_MODE: r_ext_mode    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp length, then fit it into the code width
    always_comb begin
        if (r_data_length == '0) m_clamp = hsc_pkg::POS_W'(1);
        else if (r_data_length > M_MAX) m_clamp = M_MAX;
        else m_clamp = r_data_length;
        m_lim = r_ext_mode ? LIM1 : LIM0;
        m_eff = (m_clamp > m_lim) ? m_lim : m_clamp;
    end

    assign o_geom.m   = m_eff;
    assign o_geom.nb  = m_eff + hsc_pkg::POS_W'(hsc_pkg::parity_count(int'(m_eff)));
    assign o_geom.ext = r_ext_mode;

endmodule

### hdl/hsc_encode.sv
// ----------------------------------------------------------------------------
// hsc_encode
// scatters data bits and fills the hamming parity positions
// ----------------------------------------------------------------------------
module hsc_encode (
    input  logic [hsc_pkg::CODE_W-1:0] i_word,
    input  hsc_pkg::t_geom             i_geom,
    output logic [hsc_pkg::CODE_W-1:0] o_code
);

    logic [hsc_pkg::BASE_W-1:0] data_base;
    logic [hsc_pkg::BASE_W-1:0] full_base;

    // data bits go to the non power-of-two positions
    always_comb begin
        data_base = '0;
        for (int k = 0; k < hsc_pkg::DATA_W; k++) begin
            data_base[hsc_pkg::data_pos(k) - 1] =
                i_word[k] & (hsc_pkg::POS_W'(k) < i_geom.m);
        end
    end

    // each parity position covers the positions with its bit set
    always_comb begin
        full_base = data_base;
        for (int j = 0; j < hsc_pkg::POS_W; j++) begin
            full_base[(1 << j) - 1] = 1'b0;
            for (int i = 0; i < hsc_pkg::BASE_W; i++) begin
                if (((i + 1) & (1 << j)) != 0) begin
                    full_base[(1 << j) - 1] = full_base[(1 << j) - 1] ^ data_base[i];
                end
            end
        end
    end

    // overall parity at index zero in extended mode
    assign o_code = i_geom.ext ? {full_base, ^full_base} : {1'b0, full_base};

endmodule

### hdl/hsc_check.sv
// ----------------------------------------------------------------------------
// hsc_check
// syndrome, classification, single bit correction and data extraction
// ----------------------------------------------------------------------------
module hsc_check (
    input  logic [hsc_pkg::CODE_W-1:0] i_word,
    input  hsc_pkg::t_geom             i_geom,
    output hsc_pkg::t_result           o_res
);

    logic [hsc_pkg::BASE_W-1:0] base;
    logic [hsc_pkg::BASE_W-1:0] fixed;
    logic [hsc_pkg::POS_W-1:0]  synd;
    logic                       ovp;
    logic                       in_range;
    logic                       do_flip;
    hsc_pkg::t_status           status;
    logic [hsc_pkg::POS_W-1:0]  eidx;
    logic [hsc_pkg::DATA_W-1:0] data;

    // strip the overall parity bit and bits beyond the code length
    always_comb begin
        ovp = 1'b0;
        for (int i = 0; i < hsc_pkg::BASE_W; i++) begin
            base[i] = (i_geom.ext ? i_word[i + 1] : i_word[i])
                      & (hsc_pkg::POS_W'(i) < i_geom.nb);
        end
        for (int i = 0; i < hsc_pkg::CODE_W; i++) begin
            ovp = ovp ^ (i_word[i] & (hsc_pkg::POS_W'(i) <= i_geom.nb));
        end
        ovp = ovp & i_geom.ext;
    end

    // syndrome bit j is the parity of positions with bit j set
    always_comb begin
        synd = '0;
        for (int j = 0; j < hsc_pkg::POS_W; j++) begin
            for (int i = 0; i < hsc_pkg::BASE_W; i++) begin
                if (((i + 1) & (1 << j)) != 0) synd[j] = synd[j] ^ base[i];
            end
        end
    end

    // classify the word
    always_comb begin
        in_range = (synd <= i_geom.nb);
        do_flip  = 1'b0;
        status   = hsc_pkg::ST_CLEAN;
        eidx     = '0;
        if (i_geom.ext) begin
            if (synd == '0) begin
                status = ovp ? hsc_pkg::ST_PARITY : hsc_pkg::ST_CLEAN;
            end else if (ovp && in_range) begin
                status  = hsc_pkg::ST_SINGLE;
                eidx    = synd;
                do_flip = 1'b1;
            end else begin
                status = hsc_pkg::ST_DOUBLE;
            end
        end else if (synd != '0) begin
            if (in_range) begin
                status  = hsc_pkg::ST_SINGLE;
                eidx    = synd - hsc_pkg::POS_W'(1);
                do_flip = 1'b1;
            end else begin
                status = hsc_pkg::ST_DOUBLE;
            end
        end
    end

    // correct the named bit and gather the data positions
    always_comb begin
        for (int i = 0; i < hsc_pkg::BASE_W; i++) begin
            fixed[i] = base[i] ^ (do_flip && (synd == hsc_pkg::POS_W'(i + 1)));
        end
        for (int k = 0; k < hsc_pkg::DATA_W; k++) begin
            data[k] = fixed[hsc_pkg::data_pos(k) - 1] & (hsc_pkg::POS_W'(k) < i_geom.m);
        end
    end

    assign o_res.code_word      = '0;
    assign o_res.data_out       = data;
    assign o_res.syndrome       = synd;
    assign o_res.overall_parity = ovp;
    assign o_res.status         = status;
    assign o_res.error_index    = eidx;

endmodule

### hdl/hamming_secded_codec_top.sv
// ----------------------------------------------------------------------------
// hamming_secded_codec_top
// hamming encoder and secded checker; unless the result side stalls, one word per clock
// ----------------------------------------------------------------------------
// Each word passes an input register and then a result register. A new word is
// taken every clock while the result side does not stall. The parity xor trees
// between the input and result registers set the clock limit.
// A waiting result does not block the input register, so one more word is
// taken while the result side stalls. Registers: index 0 data_length (1..57,
// clamped and fitted to MAX_CODE_BITS), index 1 extended_mode (overall parity
// at codeword index 0). Write them only while no word is in flight; the
// register port is always ready.
module hamming_secded_codec_top #(
    parameter int MAX_CODE_BITS = hsc_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_op,
    input  logic [hsc_pkg::CODE_W-1:0] i_word_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [hsc_pkg::CODE_W-1:0] o_code_word,
    output logic [hsc_pkg::DATA_W-1:0] o_data_out,
    output logic [hsc_pkg::POS_W-1:0]  o_syndrome,
    output logic                      o_overall_parity,
    output logic [1:0]                o_status,
    output logic [hsc_pkg::POS_W-1:0]  o_error_index,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [hsc_pkg::POS_W-1:0]  i_cfg_data
);

    hsc_pkg::t_geom             geom;
    logic                       r_in_valid;
    logic                       r_op;
    logic [hsc_pkg::CODE_W-1:0] r_word;
    logic                       r_out_valid;
    hsc_pkg::t_result           r_res;
    hsc_pkg::t_result           n_res;
    hsc_pkg::t_result           chk_res;
    logic [hsc_pkg::CODE_W-1:0] enc_code;
    logic                       adv;

    hsc_cfg #(
        .MAX_CODE_BITS(MAX_CODE_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (geom)
    );

    hsc_encode u_encode (
        .i_word (r_word),
        .i_geom (geom),
        .o_code (enc_code)
    );

    hsc_check u_check (
        .i_word (r_word),
        .i_geom (geom),
        .o_res  (chk_res)
    );

    // pipeline flow control
    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || adv;

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op   <= i_op;
            r_word <= i_word_in;
        end
    end

    // pick the result of the requested operation
    always_comb begin
        if (r_op == hsc_pkg::OP_ENCODE) begin
            n_res                = '0;
            n_res.code_word      = enc_code;
            n_res.status         = hsc_pkg::ST_CLEAN;
        end else begin
            n_res = chk_res;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_code_word      = r_res.code_word;
    assign o_data_out       = r_res.data_out;
    assign o_syndrome       = r_res.syndrome;
    assign o_overall_parity = r_res.overall_parity;
    assign o_status         = r_res.status;
    assign o_error_index    = r_res.error_index;

    // a corrected word always has a nonzero syndrome
    a_single_has_synd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == hsc_pkg::ST_SINGLE) |-> (o_syndrome != '0))
        else $error("single error reported with zero syndrome");

    // parity bit error only with odd overall parity
    a_parity_needs_ovp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == hsc_pkg::ST_PARITY) |-> o_overall_parity)
        else $error("parity bit error without odd overall parity");

    // uncorrectable words name no bit
    a_double_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == hsc_pkg::ST_DOUBLE) |-> (o_error_index == '0))
        else $error("double error with nonzero error index");

    // a taken word lands in the input register
    a_in_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_in_valid)
        else $error("accepted word lost at input register");

    // a stalled result keeps the next word waiting, not dropped
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |=> r_in_valid && r_out_valid)
        else $error("word dropped during output stall");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming secded codec testbench
// Sends encode and check words through the codec. Valid and ready stall at
// random on both channels. Each result word is compared field by field with
// a local hamming encoder and syndrome decoder. The run steps through several
// data lengths with and without the overall parity bit.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_BITS = hsc_pkg::MAX_CODE_BITS_DEF;

    typedef struct packed {
        logic                       op;
        logic [hsc_pkg::CODE_W-1:0] word;
    } t_codec_word;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #10 i_clk = ~i_clk;

    // block inputs
    logic                       in_valid = 1'b0;
    logic                       in_op = hsc_pkg::OP_ENCODE;
    logic [hsc_pkg::CODE_W-1:0] in_word = '0;
    logic                       out_ready = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_index = hsc_pkg::CFG_DATA_LENGTH;
    logic [hsc_pkg::POS_W-1:0]  cfg_data = '0;

    // block outputs
    logic                       o_in_ready;
    logic                       o_out_valid;
    logic [hsc_pkg::CODE_W-1:0] o_code_word;
    logic [hsc_pkg::DATA_W-1:0] o_data_out;
    logic [hsc_pkg::POS_W-1:0]  o_syndrome;
    logic                       o_overall_parity;
    logic [1:0]                 o_status;
    logic [hsc_pkg::POS_W-1:0]  o_error_index;
    logic                       o_cfg_ready;

    // local copy of the register settings
    logic [hsc_pkg::POS_W-1:0] cfg_len = 6'd57;
    logic                      cfg_ext = 1'b0;

    t_codec_word      pending_words[$];
    hsc_pkg::t_result expected_results[$];
    t_codec_word      next_word;
    hsc_pkg::t_result want_result;
    int               idle_rate = 4;
    int               gap_left = 0;
    int               stall_left = 0;
    bit               long_hold_done = 1'b0;
    int               results_seen = 0;
    int               mismatch_count = 0;

    hamming_secded_codec_top #(
        .MAX_CODE_BITS(MAX_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (in_op),
        .i_word_in        (in_word),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_code_word      (o_code_word),
        .o_data_out       (o_data_out),
        .o_syndrome       (o_syndrome),
        .o_overall_parity (o_overall_parity),
        .o_status         (o_status),
        .o_error_index    (o_error_index),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    // ------------------------------------------------------------------
    // code arithmetic
    // ------------------------------------------------------------------
    function automatic int parity_bits(input int m);
        int p;
        p = 0;
        while ((1 << p) < m + p + 1) p++;
        return p;
    endfunction

    function automatic bit is_pow2(input int v);
        return v != 0 && (v & (v - 1)) == 0;
    endfunction

    function automatic logic [hsc_pkg::CODE_W-1:0] low_mask(input int n);
        if (n >= hsc_pkg::CODE_W) return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    // effective data length and base code length for the current settings
    function automatic void code_shape(output int m, output int nb);
        int ext_bits;
        ext_bits = cfg_ext;
        m = cfg_len;
        if (m < 1) m = 1;
        if (m > hsc_pkg::DATA_MAX) m = hsc_pkg::DATA_MAX;
        while (m > 1 && m + parity_bits(m) + ext_bits > MAX_BITS) m--;
        nb = m + parity_bits(m);
    endfunction

    function automatic logic [hsc_pkg::CODE_W-1:0] hamming_encode(
        input logic [hsc_pkg::CODE_W-1:0] data, input int m, input int nb, input bit ext);
        logic [hsc_pkg::CODE_W-1:0] base;
        int                         k;
        bit                         x;
        base = '0;
        k = 0;
        // data bits go to the non power of two positions in order
        for (int pos = 1; pos <= nb; pos++) begin
            if (!is_pow2(pos)) begin
                if (k < m && data[k]) base[pos-1] = 1'b1;
                k++;
            end
        end
        // even parity over the positions sharing each weight
        for (int pw = 1; pw <= nb; pw = pw << 1) begin
            x = 1'b0;
            for (int q = pw + 1; q <= nb; q++) begin
                if ((q & pw) != 0 && base[q-1]) x = ~x;
            end
            if (x) base[pw-1] = 1'b1;
        end
        if (ext) return {base[hsc_pkg::CODE_W-2:0], ^base};
        return base;
    endfunction

    function automatic hsc_pkg::t_result predict_codec_result(
        input logic op, input logic [hsc_pkg::CODE_W-1:0] w);
        hsc_pkg::t_result           r;
        int                         m;
        int                         nb;
        int                         synd;
        int                         eidx;
        int                         k;
        logic [hsc_pkg::CODE_W-1:0] base;
        logic [hsc_pkg::CODE_W-1:0] data;
        bit                         ovp;
        hsc_pkg::t_status           st;
        r = '0;
        code_shape(m, nb);
        if (op == hsc_pkg::OP_ENCODE) begin
            r.code_word = hamming_encode(w, m, nb, cfg_ext);
        end else begin
            ovp = 1'b0;
            if (cfg_ext) begin
                base = (w >> 1) & low_mask(nb);
                ovp = ^(w & low_mask(nb + 1));
            end else begin
                base = w & low_mask(nb);
            end
            synd = 0;
            for (int pos = 1; pos <= nb; pos++) begin
                if (base[pos-1]) synd ^= pos;
            end
            st = hsc_pkg::ST_CLEAN;
            eidx = 0;
            if (cfg_ext) begin
                // even overall parity with a syndrome means two bits flipped
                if (synd == 0) begin
                    st = ovp ? hsc_pkg::ST_PARITY : hsc_pkg::ST_CLEAN;
                end else if (ovp && synd <= nb) begin
                    st = hsc_pkg::ST_SINGLE;
                    eidx = synd;
                    base[synd-1] = ~base[synd-1];
                end else begin
                    st = hsc_pkg::ST_DOUBLE;
                end
            end else if (synd != 0) begin
                // a syndrome past the code length names no bit
                if (synd <= nb) begin
                    st = hsc_pkg::ST_SINGLE;
                    eidx = synd - 1;
                    base[synd-1] = ~base[synd-1];
                end else begin
                    st = hsc_pkg::ST_DOUBLE;
                end
            end
            data = '0;
            k = 0;
            for (int pos = 1; pos <= nb; pos++) begin
                if (!is_pow2(pos)) begin
                    data[k] = base[pos-1];
                    k++;
                end
            end
            data = data & low_mask(m);
            r.data_out = data[hsc_pkg::DATA_W-1:0];
            r.syndrome = synd[hsc_pkg::POS_W-1:0];
            r.overall_parity = ovp;
            r.status = st;
            r.error_index = eidx[hsc_pkg::POS_W-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_word(input logic op, input logic [hsc_pkg::CODE_W-1:0] w);
        t_codec_word it;
        it.op = op;
        it.word = w;
        pending_words.push_back(it);
    endtask

    function automatic logic [hsc_pkg::CODE_W-1:0] current_encode(
        input logic [hsc_pkg::CODE_W-1:0] data);
        int m;
        int nb;
        code_shape(m, nb);
        return hamming_encode(data, m, nb, cfg_ext);
    endfunction

    // encode words, codewords with up to two flipped bits, and some raw noise
    task automatic queue_random_words(input int count);
        int                         m;
        int                         nb;
        int                         len;
        int                         pick;
        int                         flip_at;
        logic [hsc_pkg::CODE_W-1:0] w;
        code_shape(m, nb);
        len = nb + cfg_ext;
        repeat (count) begin
            w = {$urandom, $urandom};
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
                queue_word(hsc_pkg::OP_ENCODE, w);
            end else if (pick < 17) begin
                w = hamming_encode(w, m, nb, cfg_ext);
                repeat ($urandom_range(0, 2)) begin
                    flip_at = $urandom_range(0, len - 1);
                    w[flip_at] = ~w[flip_at];
                end
                if ($urandom_range(0, 3) == 0) w = w | ({$urandom, $urandom} & ~low_mask(len));
                queue_word(hsc_pkg::OP_CHECK, w);
            end else begin
                queue_word($urandom_range(0, 1) ? hsc_pkg::OP_CHECK : hsc_pkg::OP_ENCODE, w);
            end
        end
    endtask

    // wait until every queued word has gone through and come back
    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [hsc_pkg::POS_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == hsc_pkg::CFG_DATA_LENGTH) cfg_len = val;
        else cfg_ext = val[0];
    endtask

    // ------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && o_in_ready)
                expected_results.push_back(predict_codec_result(in_op, in_word));
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    in_valid <= 1'b0;
                    gap_left--;
                end else if (pending_words.size() != 0 && idle_rate != 0 &&
                             $urandom_range(1, 16) <= idle_rate) begin
                    in_valid <= 1'b0;
                    gap_left = $urandom_range(0, 4);
                end else if (pending_words.size() != 0) begin
                    next_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    in_op <= next_word.op;
                    in_word <= next_word.word;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor and ready control
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("result word %0d arrived with nothing expected", results_seen);
                    mismatch_count++;
                end else begin
                    want_result = expected_results.pop_front();
                    if (o_code_word !== want_result.code_word ||
                        o_data_out !== want_result.data_out ||
                        o_syndrome !== want_result.syndrome ||
                        o_overall_parity !== want_result.overall_parity ||
                        o_status !== want_result.status ||
                        o_error_index !== want_result.error_index) begin
                        if (mismatch_count < 10) begin
                            $display("result word %0d mismatch (len %0d ext %0d)",
                                     results_seen, cfg_len, cfg_ext);
                            $display("  exp code %h data %h syn %0d ovp %0d st %0d idx %0d",
                                     want_result.code_word, want_result.data_out,
                                     want_result.syndrome, want_result.overall_parity,
                                     want_result.status, want_result.error_index);
                            $display("  got code %h data %h syn %0d ovp %0d st %0d idx %0d",
                                     o_code_word, o_data_out, o_syndrome,
                                     o_overall_parity, o_status, o_error_index);
                        end
                        mismatch_count++;
                    end
                end
            end
            // one long hold while the sender keeps pushing, else short bursts
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if (!long_hold_done && results_seen >= 100 &&
                         pending_words.size() > 40) begin
                out_ready <= 1'b0;
                stall_left = 63;
                long_hold_done = 1'b1;
            end else if (idle_rate != 0 && $urandom_range(1, 16) <= idle_rate) begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 4);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [hsc_pkg::CODE_W-1:0] cw;
        logic [hsc_pkg::POS_W-1:0]  len_pick;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: 57 data bits, no overall parity
        queue_word(hsc_pkg::OP_ENCODE, '0);
        queue_word(hsc_pkg::OP_ENCODE, '1);
        queue_word(hsc_pkg::OP_CHECK, '0);
        queue_word(hsc_pkg::OP_CHECK, '1);
        cw = current_encode({$urandom, $urandom});
        queue_word(hsc_pkg::OP_CHECK, cw ^ (64'd1 << 62));
        queue_word(hsc_pkg::OP_CHECK, cw ^ 64'd1);
        wait_drained();

        // length above range acts as 57, with overall parity
        write_reg(hsc_pkg::CFG_DATA_LENGTH, 6'd63);
        write_reg(hsc_pkg::CFG_EXTENDED_MODE, 6'd1);
        queue_word(hsc_pkg::OP_ENCODE, '1);
        cw = current_encode({$urandom, $urandom});
        queue_word(hsc_pkg::OP_CHECK, cw);
        queue_word(hsc_pkg::OP_CHECK, cw ^ 64'd1);
        queue_word(hsc_pkg::OP_CHECK, cw ^ (64'd1 << 40));
        queue_word(hsc_pkg::OP_CHECK, cw ^ (64'd1 << 5) ^ (64'd1 << 33));
        queue_word(hsc_pkg::OP_CHECK, '1);
        wait_drained();

        // short code where the syndrome can point past the word
        write_reg(hsc_pkg::CFG_DATA_LENGTH, 6'd5);
        write_reg(hsc_pkg::CFG_EXTENDED_MODE, 6'd0);
        queue_word(hsc_pkg::OP_CHECK, 64'h0000_0000_0000_008B);
        queue_word(hsc_pkg::OP_CHECK, 64'hFFFF_FFFF_FFFF_FC8B);
        queue_word(hsc_pkg::OP_ENCODE, '1);
        wait_drained();

        // zero length acts as one data bit
        write_reg(hsc_pkg::CFG_DATA_LENGTH, 6'd0);
        write_reg(hsc_pkg::CFG_EXTENDED_MODE, 6'd1);
        queue_word(hsc_pkg::OP_ENCODE, '0);
        queue_word(hsc_pkg::OP_ENCODE, '1);
        queue_word(hsc_pkg::OP_CHECK, '1);
        queue_word(hsc_pkg::OP_CHECK, 64'd2);
        wait_drained();

        // random phases, each with its own settings; the last one runs flat out
        for (int ph = 0; ph < 10; ph++) begin
            wait_drained();
            case ($urandom_range(0, 5))
                0: len_pick = 6'd0;
                1: len_pick = 6'd63;
                2: len_pick = 6'd57;
                3: len_pick = 6'd1;
                default: len_pick = hsc_pkg::POS_W'($urandom_range(0, 63));
            endcase
            write_reg(hsc_pkg::CFG_DATA_LENGTH, len_pick);
            write_reg(hsc_pkg::CFG_EXTENDED_MODE, hsc_pkg::POS_W'($urandom_range(0, 1)));
            idle_rate = (ph == 9) ? 0 : int'($urandom_range(0, 6));
            queue_random_words((ph == 9) ? 60 : 76);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule

### sim.f
hdl/hsc_pkg.sv
hdl/hsc_cfg.sv
hdl/hsc_encode.sv
hdl/hsc_check.sv
hdl/hamming_secded_codec_top.sv
bench/testbench.sv
